// ----- rtl/tat_pkg.sv -----
// Shared constants for the accelerometer tilt-angle pipeline.
// Holds the CORDIC arctangent table and the output range limits; no dependencies.
package tat_pkg;

	localparam int ATAN_LEN = 24;
	localparam int ANG_W    = 25;
	localparam int OUT_W    = 16;

	localparam logic signed [ANG_W-1:0] DEG90_ANG = 25'sd23040;
	localparam logic signed [OUT_W-1:0] DEG90_OUT = 16'sd23040;
	localparam logic signed [ANG_W-1:0] RND_HALF  = 25'sd128;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0:       v = 25'sd2949120;
			1:       v = 25'sd1740967;
			2:       v = 25'sd919879;
			3:       v = 25'sd466945;
			4:       v = 25'sd234379;
			5:       v = 25'sd117304;
			6:       v = 25'sd58666;
			7:       v = 25'sd29335;
			8:       v = 25'sd14668;
			9:       v = 25'sd7334;
			10:      v = 25'sd3667;
			11:      v = 25'sd1833;
			12:      v = 25'sd917;
			13:      v = 25'sd458;
			14:      v = 25'sd229;
			15:      v = 25'sd115;
			16:      v = 25'sd57;
			17:      v = 25'sd29;
			18:      v = 25'sd14;
			19:      v = 25'sd7;
			20:      v = 25'sd4;
			21:      v = 25'sd2;
			22:      v = 25'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/tat_lane.sv -----
// One tilt angle: atan(num / sqrt(a*a + b*b)) as a fully pipelined datapath.
// Squares, a one-bit-per-stage square root, one CORDIC step per stage, rounding.
// Depends on tat_pkg.
module tat_lane #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic signed [SAMPLE_WIDTH-1:0]       num,
	input  logic signed [SAMPLE_WIDTH-1:0]       a,
	input  logic signed [SAMPLE_WIDTH-1:0]       b,
	output logic                                 out_vld,
	output logic signed [tat_pkg::OUT_W-1:0]     angle,
	output logic                                 undef
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int R  = W + 8;        // root bits
	localparam int CW = W + 19;       // CORDIC vector width
	localparam int AW = tat_pkg::ANG_W;
	localparam int N  = (CORDIC_STEPS < tat_pkg::ATAN_LEN) ? CORDIC_STEPS : tat_pkg::ATAN_LEN;

	// stage 1: squares
	logic                   vld_s1;
	logic signed [W-1:0]    num_s1;
	logic signed [2*W-1:0]  pa_s1, pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= num;
		pa_s1  <= (2*W)'(a) * (2*W)'(a);
		pb_s1  <= (2*W)'(b) * (2*W)'(b);
	end

	// stage 2: sum of squares (fits 2W bits unsigned)
	logic                   vld_s2;
	logic signed [W-1:0]    num_s2;
	logic [2*W-1:0]         sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2 <= num_s1;
		sum_s2 <= $unsigned(pa_s1) + $unsigned(pb_s1);
	end

	// square root stages, one root bit each; radicand is sum * 2^16
	logic                   sq_vld_sx [R];
	logic [R-1:0]           sq_rt_sx  [R];
	logic [R-1:0]           sq_rm_sx  [R];
	logic [2*R-1:0]         sq_rd_sx  [R];
	logic signed [W-1:0]    sq_num_sx [R];
	logic                   sq_sz_sx  [R];

	for (genvar k = 0; k < R; k++) begin : g_sq
		logic                v_in, sz_in;
		logic [R-1:0]        rt_in, rm_in;
		logic [2*R-1:0]      rd_in;
		logic signed [W-1:0] num_in;
		logic [R+1:0]        r2, tr, diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign v_in   = vld_s2;
			assign rt_in  = '0;
			assign rm_in  = '0;
			assign rd_in  = {sum_s2, 16'b0};
			assign num_in = num_s2;
			assign sz_in  = (sum_s2 == '0);
		end else begin : g_next
			assign v_in   = sq_vld_sx[k-1];
			assign rt_in  = sq_rt_sx[k-1];
			assign rm_in  = sq_rm_sx[k-1];
			assign rd_in  = sq_rd_sx[k-1];
			assign num_in = sq_num_sx[k-1];
			assign sz_in  = sq_sz_sx[k-1];
		end

		always_comb begin
			r2   = {rm_in, rd_in[2*R-1 -: 2]};
			tr   = {rt_in, 2'b01};
			diff = r2 - tr;
			ge   = (r2 >= tr);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_sx[k] <= 1'b0;
			end else begin
				sq_vld_sx[k] <= v_in;
			end
		end

		// remainder stays below 2^R until the last stage, where it is not used
		always_ff @(posedge clk) begin
			sq_rt_sx[k]  <= {rt_in[R-2:0], ge};
			sq_rm_sx[k]  <= ge ? diff[R-1:0] : r2[R-1:0];
			sq_rd_sx[k]  <= rd_in << 2;
			sq_num_sx[k] <= num_in;
			sq_sz_sx[k]  <= sz_in;
		end
	end

	// CORDIC vectoring stages on (d, n)
	logic                   co_vld_sx [N];
	logic signed [CW-1:0]   co_d_sx   [N];
	logic signed [CW-1:0]   co_n_sx   [N];
	logic signed [AW-1:0]   co_a_sx   [N];
	logic                   co_neg_sx [N];
	logic                   co_nz_sx  [N];
	logic                   co_sz_sx  [N];

	for (genvar i = 0; i < N; i++) begin : g_co
		logic                 v_in, neg_in, nz_in, sz_in;
		logic signed [CW-1:0] d_in, n_in, dd, dn;
		logic signed [AW-1:0] a_in;

		if (i == 0) begin : g_first
			assign v_in   = sq_vld_sx[R-1];
			assign d_in   = $signed({3'b0, sq_rt_sx[R-1], 8'b0});
			assign n_in   = $signed({{3{sq_num_sx[R-1][W-1]}}, sq_num_sx[R-1], 16'b0});
			assign a_in   = '0;
			assign neg_in = sq_num_sx[R-1][W-1];
			assign nz_in  = (sq_num_sx[R-1] == '0);
			assign sz_in  = sq_sz_sx[R-1];
		end else begin : g_next
			assign v_in   = co_vld_sx[i-1];
			assign d_in   = co_d_sx[i-1];
			assign n_in   = co_n_sx[i-1];
			assign a_in   = co_a_sx[i-1];
			assign neg_in = co_neg_sx[i-1];
			assign nz_in  = co_nz_sx[i-1];
			assign sz_in  = co_sz_sx[i-1];
		end

		assign dd = d_in >>> i;
		assign dn = n_in >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				co_vld_sx[i] <= 1'b0;
			end else begin
				co_vld_sx[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (!n_in[CW-1]) begin
				co_d_sx[i] <= d_in + dn;
				co_n_sx[i] <= n_in - dd;
				co_a_sx[i] <= a_in + tat_pkg::atan_q16(i);
			end else begin
				co_d_sx[i] <= d_in - dn;
				co_n_sx[i] <= n_in + dd;
				co_a_sx[i] <= a_in - tat_pkg::atan_q16(i);
			end
			co_neg_sx[i] <= neg_in;
			co_nz_sx[i]  <= nz_in;
			co_sz_sx[i]  <= sz_in;
		end
	end

	// output stage: round half up to 1/256 degree, clamp, special cases
	logic signed [AW-1:0]              rsum, rsh;
	logic signed [tat_pkg::OUT_W-1:0]  ang_nx;
	logic                              und_nx;

	always_comb begin
		rsum   = co_a_sx[N-1] + tat_pkg::RND_HALF;
		rsh    = rsum >>> 8;
		und_nx = 1'b0;
		if (rsh > tat_pkg::DEG90_ANG) begin
			ang_nx = tat_pkg::DEG90_OUT;
		end else if (rsh < -tat_pkg::DEG90_ANG) begin
			ang_nx = -tat_pkg::DEG90_OUT;
		end else begin
			ang_nx = rsh[tat_pkg::OUT_W-1:0];
		end
		if (co_nz_sx[N-1]) begin
			ang_nx = '0;
			und_nx = co_sz_sx[N-1];
		end else if (co_sz_sx[N-1]) begin
			ang_nx = co_neg_sx[N-1] ? -tat_pkg::DEG90_OUT : tat_pkg::DEG90_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= co_vld_sx[N-1];
		end
	end

	always_ff @(posedge clk) begin
		angle <= ang_nx;
		undef <= und_nx;
	end

endmodule

// ----- rtl/accel_tilt_angles_top.sv -----
// Top level of the accelerometer tilt-angle block: roll and pitch lanes.
// Depends on tat_pkg and tat_lane.
//
// Usage:
//   A request (accel_x, accel_y, accel_z) is taken at a rising edge with start
//   high and busy low. busy is always low: a new sample may be given every
//   cycle, with no dependence between samples.
//   Each result (roll_angle, pitch_angle and the two undefined flags) shows on
//   the result ports for one cycle with done high; results leave in request
//   order. The receiver cannot stall, so nothing is held back.
//   The pipeline has a squares stage, a sum-of-squares stage, SAMPLE_WIDTH+8
//   square-root stages (one root bit each), one stage per CORDIC step
//   (min(CORDIC_STEPS,24) steps) and one rounding stage.
//   Throughput is one sample per cycle.
//   Reset clears all stage valid bits, so no result is shown for requests
//   still in flight at reset.
//   Angles are in 1/256 degree within +-90 degrees; a flag marks 0/0.
module accel_tilt_angles_top #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [SAMPLE_WIDTH-1:0]    accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0]    accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0]    accel_z,
	output logic                              done,
	output logic signed [tat_pkg::OUT_W-1:0]  roll_angle,
	output logic signed [tat_pkg::OUT_W-1:0]  pitch_angle,
	output logic                              roll_undefined,
	output logic                              pitch_undefined
);

	logic pitch_vld;

	assign busy = 1'b0;

	tat_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.num     (accel_x),
		.a       (accel_y),
		.b       (accel_z),
		.out_vld (done),
		.angle   (roll_angle),
		.undef   (roll_undefined)
	);

	tat_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.num     (accel_y),
		.a       (accel_x),
		.b       (accel_z),
		.out_vld (pitch_vld),
		.angle   (pitch_angle),
		.undef   (pitch_undefined)
	);

	// both lanes have the same depth, so their strobes coincide
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done == pitch_vld)
		else $error("roll and pitch lanes out of step");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (roll_undefined || pitch_undefined) |->
		(!roll_undefined || roll_angle == '0) && (!pitch_undefined || pitch_angle == '0))
		else $error("undefined angle not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> roll_angle <= tat_pkg::DEG90_OUT && roll_angle >= -tat_pkg::DEG90_OUT &&
		pitch_angle <= tat_pkg::DEG90_OUT && pitch_angle >= -tat_pkg::DEG90_OUT)
		else $error("angle beyond 90 degrees");

endmodule

// ----- tb/accel_tilt_angles_top_tb.sv -----
// Testbench for accel_tilt_angles_top: drives accelerometer samples and checks roll/pitch.
// Depends on tat_pkg and the RTL of accel_tilt_angles_top; self-contained otherwise.
`timescale 1ns / 100ps

module accel_tilt_angles_top_tb;

	localparam int SW     = 16;
	localparam int STEPS  = 16;
	localparam int LAT    = SW + STEPS + 11;
	localparam int WDOG   = 2000;
	localparam int N_RAND = 1030;

	typedef struct packed {
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic               roll_u;
		logic               pitch_u;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [SW-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic busy, done, roll_undefined, pitch_undefined;
	logic signed [15:0] roll_angle, pitch_angle;

	sample_t pending_q[$];
	tilt_t   angles_q[$];
	int      errors = 0;
	int      n_sent = 0;
	int      n_got = 0;
	int      n_undef = 0;
	int      idle_left = 0;
	int      quiet = 0;
	bit      gen_done = 0;
	bit      no_idle = 0;

	accel_tilt_angles_top #(.SAMPLE_WIDTH(SW), .CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.roll_undefined(roll_undefined), .pitch_undefined(pitch_undefined)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint atan_step(int i);
		longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return t[i];
	endfunction

	// atan(num / |(a,b)|) in 1/256 degree; und set on 0/0
	function automatic longint tilt_angle(longint num, longint a, longint b, output logic und);
		longint unsigned s;
		longint d, n, ang, dn, dd, r;
		s = longint'(a * a) + longint'(b * b);
		und = 1'b0;
		ang = 0;
		if (num == 0) begin
			und = (s == 0);
			return 0;
		end
		if (s == 0) return (num > 0) ? 23040 : -23040;
		d = longint'(root64(s << 16)) * 256;
		n = num * 65536;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dn = n >>> i;
			dd = d >>> i;
			if (n >= 0) begin
				d = d + dn;
				n = n - dd;
				ang = ang + atan_step(i);
			end else begin
				d = d - dn;
				n = n + dd;
				ang = ang - atan_step(i);
			end
		end
		r = (ang + 128) >>> 8;
		if (r > 23040) r = 23040;
		if (r < -23040) r = -23040;
		return r;
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		tilt_t t;
		longint x, y, z;
		x = s.x;
		y = s.y;
		z = s.z;
		t.roll = 16'(tilt_angle(x, y, z, t.roll_u));
		t.pitch = 16'(tilt_angle(y, x, z, t.pitch_u));
		return t;
	endfunction

	function automatic logic signed [SW-1:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return SW'($signed($urandom_range(0, 16)) - 8);
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic add_sample(logic signed [SW-1:0] x, y, z);
		pending_q.push_back('{x: x, y: y, z: z});
	endtask

	initial begin
		// zero cases, both-zero per axis, extremes, single-axis gravity
		add_sample(0, 0, 0);
		add_sample(0, 0, 100);
		add_sample(100, 0, 0);
		add_sample(-100, 0, 0);
		add_sample(0, 100, 0);
		add_sample(0, -100, 0);
		add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_sample(16'sh8000, 16'sh8000, 16'sh8000);
		add_sample(16'sh7fff, 16'sh8000, 0);
		add_sample(16'sh8000, 0, 16'sh7fff);
		add_sample(0, 16'sh8000, 16'sh8000);
		add_sample(1, 1, 1);
		add_sample(-1, -1, -1);
		add_sample(1, 0, 0);
		add_sample(0, -1, 0);
		add_sample(16384, 0, 16384);
		add_sample(0, 16384, -16384);
		add_sample(16'sh7fff, 1, 0);
		add_sample(1, 16'sh8000, 0);
		add_sample(-16384, 16384, 0);
		for (int i = 0; i < N_RAND; i++)
			add_sample(rand_axis(), rand_axis(), rand_axis());
		gen_done = 1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) n_sent <= n_sent + 1;
			if (start && busy) begin
				// hold request until taken
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_q.size() > 0) begin
				if (!no_idle && $urandom_range(0, 15) == 0) begin
					start <= 1'b0;
					idle_left <= $urandom_range(0, 18);
				end else begin
					sample_t s;
					s = pending_q.pop_front();
					angles_q.push_back(predict_tilt(s));
					accel_x <= s.x;
					accel_y <= s.y;
					accel_z <= s.z;
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
			no_idle <= pending_q.size() < 150;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				tilt_t e;
				n_got <= n_got + 1;
				if (angles_q.size() == 0) begin
					$display("%0t: result with no request pending: roll %0d pitch %0d",
						$time, roll_angle, pitch_angle);
					errors <= errors + 1;
				end else begin
					e = angles_q.pop_front();
					if (roll_undefined || pitch_undefined) n_undef <= n_undef + 1;
					if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
						e.roll_u !== roll_undefined || e.pitch_u !== pitch_undefined) begin
						$display("%0t: mismatch exp roll %0d pitch %0d ru %b pu %b",
							$time, e.roll, e.pitch, e.roll_u, e.pitch_u);
						$display("%0t:          got roll %0d pitch %0d ru %b pu %b",
							$time, roll_angle, pitch_angle, roll_undefined, pitch_undefined);
						errors <= errors + 1;
					end
				end
			end
			quiet <= ((start && !busy) || done) ? 0 : quiet + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (gen_done);
		while (pending_q.size() > 0 || start || angles_q.size() > 0) begin
			@(posedge clk);
			if (quiet >= WDOG) begin
				$display("timeout after %0d idle cycles", quiet);
				$display("tb: failure");
				$finish;
			end
		end
		repeat (LAT + 10) @(posedge clk);
		$display("covered %0d samples, %0d results, %0d with an undefined angle",
			n_sent, n_got, n_undef);
		if (errors == 0 && angles_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
